// ----- hdl/fet_pkg.sv -----
// shared types and constants of the fat entry table
// used by fet_ctrl, fet_dp and fat_entry_table_top; no dependencies
package fet_pkg;

  localparam int MAX_ENTRIES_DEF = 4096;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_NEXT = 2'd2;
  localparam logic [1:0] MODE_INV  = 2'd3;

  localparam logic [1:0] MK_PLAIN = 2'd0;
  localparam logic [1:0] MK_END   = 2'd1;
  localparam logic [1:0] MK_BAD   = 2'd2;

  localparam logic [1:0] CFG_WIDE  = 2'd0;
  localparam logic [1:0] CFG_COUNT = 2'd1;
  localparam logic [1:0] CFG_START = 2'd2;
  localparam logic [1:0] CFG_SIZE  = 2'd3;

  localparam logic [15:0] BAD12  = 16'h0ff7;
  localparam logic [15:0] BAD16  = 16'hfff7;
  localparam logic [15:0] MASK12 = 16'h0fff;
  localparam logic [15:0] MASK16 = 16'hffff;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] cluster;
    logic [15:0] new_value;
    logic [1:0]  marker;
  } fet_in_t;

  typedef struct packed {
    logic [15:0] entry_value;
    logic [15:0] next_index;
    logic        is_end;
    logic        is_bad;
    logic        error;
    logic        write_valid;
    logic [31:0] first_addr;
    logic [31:0] second_addr;
    logic [7:0]  byte_lo;
    logic [7:0]  byte_hi;
  } fet_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic rd;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic need_rd;
  } status_t;

endpackage

// ----- hdl/fet_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module fet_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/fet_ctrl.sv -----
// sequencer of the fat entry table: handshakes and datapath commands
// depends on fet_pkg
module fet_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  fet_pkg::status_t st,
  output fet_pkg::cmd_t    cmd
);

  fet_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fet_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      fet_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = fet_pkg::ST_EXEC;
        end
      end
      fet_pkg::ST_EXEC: begin
        // bad requests need no table access
        if (st.err) begin
          cmd.fin   = 1'b1;
          state_nxt = fet_pkg::ST_OUT;
        end else begin
          cmd.rd    = st.need_rd;
          state_nxt = fet_pkg::ST_FIN;
        end
      end
      fet_pkg::ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = fet_pkg::ST_OUT;
      end
      fet_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = fet_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fet_pkg::ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == fet_pkg::ST_EXEC)
    else $error("accepted request did not start");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall))
    else $error("input open while result pending");
  a_result_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.fin))
    else $error("result shown without being built");
  a_read_before_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> cmd.fin)
    else $error("table read not followed by finish");
`endif

endmodule

// ----- hdl/fet_dp.sv -----
// datapath of the fat entry table: config registers, entry table, result build
// depends on fet_pkg and fet_ram
module fet_dp #(
  parameter int MAX_ENTRIES = fet_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fet_pkg::fet_in_t  in_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  fet_pkg::cmd_t     cmd,
  output fet_pkg::status_t  st,
  output fet_pkg::fet_out_t out_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam logic [16:0] MAX17 = 17'(MAX_ENTRIES);

  logic              wide_r;
  logic [15:0]       count_r;
  logic [31:0]       start_r;
  logic [31:0]       size_r;
  fet_pkg::fet_in_t  in_r;
  logic [31:0]       offs_r, offs_nxt;
  fet_pkg::fet_out_t res_r, res_nxt;

  logic [15:0] idx;
  logic [16:0] cnt_p1, cnt_p2;
  logic [15:0] vmask, bad, endv, v_in, set_v, store_v, ent;
  logic        err, load_wb, disk, store, is_next, nb_zero;
  logic [15:0] idx_dn, idx_up;
  logic [17:0] idx3;
  logic [AW-1:0] raddr;
  logic [15:0] rdata;
  logic [3:0]  nb_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r  <= 1'b0;
      count_r <= 16'd1;
      start_r <= '0;
      size_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fet_pkg::CFG_WIDE:  wide_r  <= cfg_data[0];
        fet_pkg::CFG_COUNT: count_r <= cfg_data[15:0];
        fet_pkg::CFG_START: start_r <= cfg_data;
        fet_pkg::CFG_SIZE:  size_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_r <= in_data;
    end
    offs_r <= offs_nxt;
    if (cmd.fin) begin
      res_r <= res_nxt;
    end
  end

  // decode of the held request
  always_comb begin
    idx     = in_r.cluster;
    cnt_p1  = {1'b0, count_r} + 17'd1;
    cnt_p2  = {1'b0, count_r} + 17'd2;
    is_next = in_r.mode == fet_pkg::MODE_NEXT;
    err     = in_r.mode == fet_pkg::MODE_INV || idx < 16'd2 ||
              {1'b0, idx} > cnt_p1 || {1'b0, idx} >= MAX17;
    vmask   = wide_r ? fet_pkg::MASK16 : fet_pkg::MASK12;
    bad     = wide_r ? fet_pkg::BAD16 : fet_pkg::BAD12;
    endv    = bad + 16'd1;
    v_in    = in_r.new_value & vmask;
    // link past the last cluster turns into end of chain
    load_wb = {1'b0, v_in} >= cnt_p2 && v_in < bad;
    case (in_r.marker)
      fet_pkg::MK_END: set_v = endv;
      fet_pkg::MK_BAD: set_v = bad;
      default:         set_v = v_in;
    endcase
    store_v = (in_r.mode == fet_pkg::MODE_LOAD) ? (load_wb ? endv : v_in) : set_v;
    store   = !err && (in_r.mode == fet_pkg::MODE_LOAD || in_r.mode == fet_pkg::MODE_SET);
    disk    = !err && (in_r.mode == fet_pkg::MODE_SET ||
                       (in_r.mode == fet_pkg::MODE_LOAD && load_wb));
    idx_dn  = idx - 16'd1;
    idx_up  = idx + 16'd1;
    nb_zero = !idx[0] && ({1'b0, idx} == cnt_p1 || {1'b0, idx_up} >= MAX17);
    if (is_next) begin
      raddr = idx[AW-1:0];
    end else if (idx[0]) begin
      raddr = idx_dn[AW-1:0];
    end else begin
      raddr = idx_up[AW-1:0];
    end
    st.err     = err;
    st.need_rd = !err && (is_next || (disk && !wide_r));
    idx3     = {1'b0, idx, 1'b0} + {2'b00, idx};
    offs_nxt = wide_r ? start_r + {15'd0, idx, 1'b0} : start_r + {15'd0, idx3[17:1]};
  end

  fet_ram #(
    .WIDTH (16),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.fin && store),
    .waddr (idx[AW-1:0]),
    .wdata (store_v),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    res_nxt = '0;
    ent     = is_next ? rdata : store_v;
    nb_lo   = nb_zero ? 4'd0 : rdata[3:0];
    if (err) begin
      res_nxt.error = 1'b1;
    end else begin
      res_nxt.entry_value = ent;
      res_nxt.is_end      = ent > bad;
      res_nxt.is_bad      = ent == bad;
      if (is_next) begin
        res_nxt.error = ent == bad;
        if (ent < bad) begin
          res_nxt.next_index = ent;
        end
      end
      if (disk) begin
        res_nxt.write_valid = 1'b1;
        res_nxt.first_addr  = offs_r;
        res_nxt.second_addr = offs_r + size_r;
        if (wide_r) begin
          res_nxt.byte_lo = store_v[7:0];
          res_nxt.byte_hi = store_v[15:8];
        end else if (idx[0]) begin
          // odd entry shares its low byte with the previous entry's top nibble
          res_nxt.byte_lo = {store_v[3:0], rdata[11:8]};
          res_nxt.byte_hi = store_v[11:4];
        end else begin
          res_nxt.byte_lo = store_v[7:0];
          res_nxt.byte_hi = {nb_lo, store_v[11:8]};
        end
      end
    end
  end

  assign out_data = res_r;

endmodule

// ----- hdl/fat_entry_table_top.sv -----
// top level of the fat12 / fat16 entry table
// depends on fet_pkg, fet_ctrl, fet_dp and fet_ram
//
// Usage:
//   in_*  : request channel (mode, cluster, new_value, marker), valid/stall.
//   out_* : result channel, one result per request, valid/stall.
//   cfg_* : register writes (index, data), taken whenever cfg_valid is high,
//           cfg_ready is always high; write only while no request is pending.
// One request is handled at a time. A request is taken in idle, the next
// cycle decodes it and reads the table (the item itself for next, the
// 12-bit neighbor for a disk write), then the entry is written and the
// result registered. A rejected request is finished in the decode state
// without a table access. The result is then shown in the output state,
// and the next request is taken the cycle after the result leaves, as the
// sequencer takes a request only from idle, never while a result is pending.
// While out_stall is high the result holds and in_stall stays high.
// Reset returns the registers to 12-bit entries, one cluster, zero
// addresses; table contents are not cleared and read as garbage until written.
module fat_entry_table_top #(
  parameter int MAX_ENTRIES = fet_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fet_pkg::fet_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fet_pkg::fet_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  fet_pkg::cmd_t    cmd;
  fet_pkg::status_t st;

  assign cfg_ready = 1'b1;

  fet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  fet_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.error && out_data.write_valid))
    else $error("error result carries a disk write");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_end && out_data.is_bad))
    else $error("entry both end and bad");
  a_next_only_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.next_index != 16'd0) |-> !out_data.is_end && !out_data.is_bad)
    else $error("next index given for end or bad entry");
`endif

endmodule
